@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the converter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define COO2CSR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define COO2CSR_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

@@ rtl/core/coo2csr_pkg.sv @@
// Shared constants, field layout and codes of the COO to CSR converter.
package coo2csr_pkg;

	localparam int MAX_ROWS_DEF    = 1024;
	localparam int MAX_ENTRIES_DEF = 4096;

	localparam int CMD_W      = 3;
	localparam int ROW_IN_W   = 11;
	localparam int COL_W      = 16;
	localparam int VAL_W      = 64;
	localparam int POS_W      = 12;
	localparam int STATUS_W   = 3;
	localparam int START_W    = 13;
	localparam int TOTAL_W    = 13;
	localparam int NUM_ROWS_W = 11;

	localparam logic [NUM_ROWS_W-1:0] NUM_ROWS_RST = 11'd1024;

	localparam int S_ROW_LSB = 0;
	localparam int S_COL_LSB = S_ROW_LSB + ROW_IN_W;
	localparam int S_VAL_LSB = S_COL_LSB + COL_W;
	localparam int S_POS_LSB = S_VAL_LSB + VAL_W;
	localparam int S_TDATA_W = ((S_POS_LSB + POS_W + 7) / 8) * 8;

	localparam int M_FIELDS_W = START_W + COL_W + VAL_W + TOTAL_W;
	localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
	localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;

	localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD     = 3'd1;
	localparam logic [CMD_W-1:0] CMD_BUILD    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_RD_PTR   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_RD_ENTRY = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_UNSORTED  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_ROW_RANGE = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
	localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd4;

	localparam int ALU_OP_W = 2;
	typedef logic [ALU_OP_W-1:0] alu_op_t;
	localparam alu_op_t ALU_ADD = 2'd0;
	localparam alu_op_t ALU_INC = 2'd1;
	localparam alu_op_t ALU_LT  = 2'd2;

endpackage

@@ rtl/core/coo2csr_ram.sv @@
// Simple dual-port RAM with one write port and one registered read port.
module coo2csr_ram #(
	parameter int WIDTH = coo2csr_pkg::VAL_W,
	parameter int DEPTH = coo2csr_pkg::MAX_ENTRIES_DEF
) (
	input  logic                                    clk,
	input  logic                                    wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                        wr_data,
	input  logic                                    rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                        rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ rtl/core/coo2csr_alu.sv @@
// Shared add, increment and compare unit of the converter sequencer.
module coo2csr_alu #(
	parameter int W = coo2csr_pkg::TOTAL_W
) (
	input  coo2csr_pkg::alu_op_t op,
	input  logic [W-1:0]         a,
	input  logic [W-1:0]         b,
	output logic [W-1:0]         res
);

	always_comb begin
		case (op)
			coo2csr_pkg::ALU_ADD: res = a + b;
			coo2csr_pkg::ALU_INC: res = a + W'(1);
			coo2csr_pkg::ALU_LT:  res = W'(a < b);
			default:              res = '0;
		endcase
	end

endmodule

@@ rtl/core/coo_to_csr_converter_core.sv @@
// Top level of the COO to CSR converter: sequencer, stores and output register.
// Usage:
//   s_tuser carries the command, s_tdata the entry fields; one transaction per command.
//   Every command returns exactly one transaction on the master side: status in m_tuser,
//   row pointer, packed entry and entry count in m_tdata.
//   cfg_valid/cfg_data write num_rows at any time; the block is meant to be idle then.
// Steps: load reads the row table, checks row range, capacity and column order, then
//   writes the row table and staging store; reads wait for a registered RAM read; an
//   unknown command or refused build goes straight to the reply; clear zeroes one row
//   of the row table per cycle; build runs one row per cycle through the prefix sum, then
//   one staged entry per cycle through the three-stage scatter; the shared adder paces both.
// One command is in work at a time: s_tready is high only when the sequencer is idle.
// After reset the whole row table is swept while s_tready stays low.
// A finished result waits in the output register while m_tready is low; the next command
// is accepted meanwhile and its result waits in the sequencer until the register frees.
`include "assert_macros.svh"

module coo_to_csr_converter_core #(
	parameter int MAX_ROWS    = coo2csr_pkg::MAX_ROWS_DEF,
	parameter int MAX_ENTRIES = coo2csr_pkg::MAX_ENTRIES_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [coo2csr_pkg::NUM_ROWS_W-1:0]    cfg_data,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// row, col, value, position
	input  logic [coo2csr_pkg::S_TDATA_W-1:0]     s_tdata,
	// cmd
	input  logic [coo2csr_pkg::CMD_W-1:0]         s_tuser,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// row_start, out_col, out_value, entry_total
	output logic [coo2csr_pkg::M_TDATA_W-1:0]     m_tdata,
	// status
	output logic [coo2csr_pkg::STATUS_W-1:0]      m_tuser
);

	localparam int COL_W    = coo2csr_pkg::COL_W;
	localparam int VAL_W    = coo2csr_pkg::VAL_W;
	localparam int ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int PTR_AW   = $clog2(MAX_ROWS + 1);
	localparam int ENT_AW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W    = $clog2(MAX_ENTRIES + 1);
	localparam int INFO_W   = 1 + COL_W + CNT_W;
	localparam int COO_W    = ROW_W + COL_W + VAL_W;
	localparam int CSR_W    = COL_W + VAL_W;
	localparam int AW       = (CNT_W > COL_W) ? CNT_W : COL_W;
	localparam int RU_W     = (PTR_AW > coo2csr_pkg::ROW_IN_W) ? PTR_AW : coo2csr_pkg::ROW_IN_W;
	localparam int PC_W     = (CNT_W > coo2csr_pkg::POS_W) ? CNT_W : coo2csr_pkg::POS_W;

	localparam logic [PTR_AW-1:0] LAST_ROW = PTR_AW'(MAX_ROWS - 1);
	localparam logic [PTR_AW-1:0] ROWS_END = PTR_AW'(MAX_ROWS);
	localparam logic [CNT_W-1:0]  ENT_FULL = CNT_W'(MAX_ENTRIES);
	localparam logic [RU_W-1:0]   ROWS_MAX = RU_W'(MAX_ROWS);

	localparam int SW = 4;
	localparam logic [SW-1:0] S_SWEEP   = 4'd0;
	localparam logic [SW-1:0] S_IDLE    = 4'd1;
	localparam logic [SW-1:0] S_LD_RD   = 4'd2;
	localparam logic [SW-1:0] S_LD_CHK  = 4'd3;
	localparam logic [SW-1:0] S_LD_WR   = 4'd4;
	localparam logic [SW-1:0] S_SUM     = 4'd5;
	localparam logic [SW-1:0] S_SUM_END = 4'd6;
	localparam logic [SW-1:0] S_SCAT    = 4'd7;
	localparam logic [SW-1:0] S_RD_WAIT = 4'd8;
	localparam logic [SW-1:0] S_REPLY   = 4'd9;

	logic [SW-1:0]                          state_q;
	logic [PTR_AW-1:0]                      idx_q;
	logic [PTR_AW-1:0]                      idx_s1;
	logic                                   reply_q;
	logic [CNT_W-1:0]                       entry_cnt_q;
	logic [coo2csr_pkg::STATUS_W-1:0]       error_q;
	logic                                   built_q;
	logic [coo2csr_pkg::NUM_ROWS_W-1:0]     num_rows_q;
	logic [coo2csr_pkg::STATUS_W-1:0]       code_q;
	logic [coo2csr_pkg::STATUS_W-1:0]       res_status_q;
	logic [CNT_W-1:0]                       acc_q;
	logic [CNT_W-1:0]                       j_q;
	logic                                   v_s1;
	logic                                   va_s1;
	logic                                   vb_s2;
	logic                                   lw_v_q;
	logic                                   m_tvalid_q;

	logic [coo2csr_pkg::CMD_W-1:0]          cmd_q;
	logic [coo2csr_pkg::ROW_IN_W-1:0]       row_q;
	logic [COL_W-1:0]                       col_q;
	logic [VAL_W-1:0]                       val_q;
	logic [ROW_W-1:0]                       row_s2;
	logic [COL_W-1:0]                       col_s2;
	logic [VAL_W-1:0]                       val_s2;
	logic [ROW_W-1:0]                       lw_row_q;
	logic [CNT_W-1:0]                       lw_slot_q;
	logic [coo2csr_pkg::START_W-1:0]        res_start_q;
	logic [COL_W-1:0]                       res_col_q;
	logic [VAL_W-1:0]                       res_val_q;
	logic [coo2csr_pkg::STATUS_W-1:0]       out_status_q;
	logic [coo2csr_pkg::START_W-1:0]        out_start_q;
	logic [COL_W-1:0]                       out_col_q;
	logic [VAL_W-1:0]                       out_val_q;
	logic [coo2csr_pkg::TOTAL_W-1:0]        out_total_q;

	logic [coo2csr_pkg::CMD_W-1:0]          in_cmd;
	logic [coo2csr_pkg::ROW_IN_W-1:0]       in_row;
	logic [COL_W-1:0]                       in_col;
	logic [VAL_W-1:0]                       in_val;
	logic [coo2csr_pkg::POS_W-1:0]          in_pos;
	logic                                   s_fire;
	logic                                   reply_load;
	logic [RU_W-1:0]                        nr_ext;
	logic [RU_W-1:0]                        rows_use;
	logic                                   ptr_ok;
	logic                                   ent_ok;
	logic [coo2csr_pkg::STATUS_W-1:0]       ld_code;

	logic                                   info_we;
	logic [ROW_W-1:0]                       info_wa;
	logic [INFO_W-1:0]                      info_wd;
	logic                                   info_re;
	logic [ROW_W-1:0]                       info_ra;
	logic [INFO_W-1:0]                      info_rd;
	logic                                   info_seen;
	logic [COL_W-1:0]                       info_col;
	logic [CNT_W-1:0]                       info_len;

	logic                                   rp_we;
	logic [PTR_AW-1:0]                      rp_wa;
	logic [CNT_W-1:0]                       rp_wd;
	logic                                   rp_re;
	logic [PTR_AW-1:0]                      rp_ra;
	logic [CNT_W-1:0]                       rp_rd;

	logic                                   slot_we;
	logic [ROW_W-1:0]                       slot_wa;
	logic [CNT_W-1:0]                       slot_wd;
	logic                                   slot_re;
	logic [ROW_W-1:0]                       slot_ra;
	logic [CNT_W-1:0]                       slot_rd;
	logic [CNT_W-1:0]                       slot_eff;

	logic                                   coo_we;
	logic [ENT_AW-1:0]                      coo_wa;
	logic [COO_W-1:0]                       coo_wd;
	logic                                   coo_re;
	logic [ENT_AW-1:0]                      coo_ra;
	logic [COO_W-1:0]                       coo_rd;
	logic [ROW_W-1:0]                       coo_rd_row;

	logic                                   csr_we;
	logic [ENT_AW-1:0]                      csr_wa;
	logic [CSR_W-1:0]                       csr_wd;
	logic                                   csr_re;
	logic [ENT_AW-1:0]                      csr_ra;
	logic [CSR_W-1:0]                       csr_rd;

	coo2csr_pkg::alu_op_t                   alu_op;
	logic [AW-1:0]                          alu_a;
	logic [AW-1:0]                          alu_b;
	logic [AW-1:0]                          alu_res;

	assign in_cmd = s_tuser;
	assign in_row = s_tdata[coo2csr_pkg::S_ROW_LSB +: coo2csr_pkg::ROW_IN_W];
	assign in_col = s_tdata[coo2csr_pkg::S_COL_LSB +: COL_W];
	assign in_val = s_tdata[coo2csr_pkg::S_VAL_LSB +: VAL_W];
	assign in_pos = s_tdata[coo2csr_pkg::S_POS_LSB +: coo2csr_pkg::POS_W];

	assign cfg_ready  = 1'b1;
	assign s_tready   = (state_q == S_IDLE);
	assign s_fire     = s_tvalid && s_tready;
	assign reply_load = (state_q == S_REPLY) && (!m_tvalid_q || m_tready);

	assign nr_ext   = RU_W'(num_rows_q);
	assign rows_use = (nr_ext == '0) ? RU_W'(1) : ((nr_ext > ROWS_MAX) ? ROWS_MAX : nr_ext);
	assign ptr_ok   = built_q && (RU_W'(in_row) <= rows_use);
	assign ent_ok   = built_q && (PC_W'(in_pos) < PC_W'(entry_cnt_q));

	assign info_seen  = info_rd[INFO_W-1];
	assign info_col   = info_rd[CNT_W +: COL_W];
	assign info_len   = info_rd[CNT_W-1:0];
	assign coo_rd_row = coo_rd[VAL_W + COL_W +: ROW_W];
	assign slot_eff   = (lw_v_q && (lw_row_q == row_s2)) ? lw_slot_q : slot_rd;

	always_comb begin
		if (RU_W'(row_q) >= rows_use) begin
			ld_code = coo2csr_pkg::ST_ROW_RANGE;
		end else if (entry_cnt_q == ENT_FULL) begin
			ld_code = coo2csr_pkg::ST_FULL;
		end else if (info_seen && !alu_res[0]) begin
			ld_code = coo2csr_pkg::ST_UNSORTED;
		end else begin
			ld_code = coo2csr_pkg::ST_OK;
		end
	end

	always_comb begin
		info_we = 1'b0;
		info_wa = '0;
		info_wd = '0;
		info_re = 1'b0;
		info_ra = '0;
		rp_we   = 1'b0;
		rp_wa   = '0;
		rp_wd   = '0;
		rp_re   = 1'b0;
		rp_ra   = '0;
		slot_we = 1'b0;
		slot_wa = '0;
		slot_wd = '0;
		slot_re = 1'b0;
		slot_ra = '0;
		coo_we  = 1'b0;
		coo_wa  = '0;
		coo_wd  = '0;
		coo_re  = 1'b0;
		coo_ra  = '0;
		csr_we  = 1'b0;
		csr_wa  = '0;
		csr_wd  = '0;
		csr_re  = 1'b0;
		csr_ra  = '0;
		alu_op  = coo2csr_pkg::ALU_ADD;
		alu_a   = '0;
		alu_b   = '0;
		case (state_q)
			S_SWEEP: begin
				info_we = 1'b1;
				info_wa = idx_q[ROW_W-1:0];
			end
			S_IDLE: begin
				rp_re  = s_fire && (in_cmd == coo2csr_pkg::CMD_RD_PTR) && ptr_ok;
				rp_ra  = PTR_AW'(in_row);
				csr_re = s_fire && (in_cmd == coo2csr_pkg::CMD_RD_ENTRY) && ent_ok;
				csr_ra = ENT_AW'(in_pos);
			end
			S_LD_RD: begin
				info_re = 1'b1;
				info_ra = ROW_W'(row_q);
			end
			S_LD_CHK: begin
				alu_op = coo2csr_pkg::ALU_LT;
				alu_a  = AW'(info_col);
				alu_b  = AW'(col_q);
			end
			S_LD_WR: begin
				alu_op = coo2csr_pkg::ALU_INC;
				alu_a  = AW'(info_len);
				if (code_q == coo2csr_pkg::ST_OK) begin
					info_we = 1'b1;
					info_wa = ROW_W'(row_q);
					info_wd = {1'b1, col_q, alu_res[CNT_W-1:0]};
					coo_we  = 1'b1;
					coo_wa  = entry_cnt_q[ENT_AW-1:0];
					coo_wd  = {ROW_W'(row_q), col_q, val_q};
				end
			end
			S_SUM: begin
				info_re = (idx_q != ROWS_END);
				info_ra = idx_q[ROW_W-1:0];
				alu_op  = coo2csr_pkg::ALU_ADD;
				alu_a   = AW'(acc_q);
				alu_b   = AW'(info_len);
				rp_we   = v_s1;
				rp_wa   = idx_s1;
				rp_wd   = acc_q;
				slot_we = v_s1;
				slot_wa = idx_s1[ROW_W-1:0];
				slot_wd = acc_q;
			end
			S_SUM_END: begin
				rp_we = 1'b1;
				rp_wa = ROWS_END;
				rp_wd = acc_q;
			end
			S_SCAT: begin
				coo_re  = (j_q != entry_cnt_q);
				coo_ra  = j_q[ENT_AW-1:0];
				slot_re = va_s1;
				slot_ra = coo_rd_row;
				alu_op  = coo2csr_pkg::ALU_INC;
				alu_a   = AW'(slot_eff);
				slot_we = vb_s2;
				slot_wa = row_s2;
				slot_wd = alu_res[CNT_W-1:0];
				csr_we  = vb_s2;
				csr_wa  = slot_eff[ENT_AW-1:0];
				csr_wd  = {col_s2, val_s2};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_SWEEP;
			idx_q        <= '0;
			reply_q      <= 1'b0;
			entry_cnt_q  <= '0;
			error_q      <= coo2csr_pkg::ST_OK;
			built_q      <= 1'b0;
			num_rows_q   <= coo2csr_pkg::NUM_ROWS_RST;
			code_q       <= coo2csr_pkg::ST_OK;
			res_status_q <= coo2csr_pkg::ST_OK;
			acc_q        <= '0;
			j_q          <= '0;
			v_s1         <= 1'b0;
			va_s1        <= 1'b0;
			vb_s2        <= 1'b0;
			lw_v_q       <= 1'b0;
			m_tvalid_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				num_rows_q <= cfg_data;
			end
			v_s1   <= (state_q == S_SUM) && (idx_q != ROWS_END);
			va_s1  <= coo_re;
			vb_s2  <= (state_q == S_SCAT) && va_s1;
			lw_v_q <= (state_q == S_SCAT) && vb_s2;
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_SWEEP: begin
					if (idx_q == LAST_ROW) begin
						state_q <= reply_q ? S_REPLY : S_IDLE;
					end else begin
						idx_q <= idx_q + PTR_AW'(1);
					end
				end
				S_IDLE: begin
					if (s_tvalid) begin
						res_status_q <= coo2csr_pkg::ST_OK;
						case (in_cmd)
							coo2csr_pkg::CMD_CLEAR: begin
								entry_cnt_q <= '0;
								error_q     <= coo2csr_pkg::ST_OK;
								built_q     <= 1'b0;
								idx_q       <= '0;
								reply_q     <= 1'b1;
								state_q     <= S_SWEEP;
							end
							coo2csr_pkg::CMD_LOAD: begin
								built_q <= 1'b0;
								state_q <= S_LD_RD;
							end
							coo2csr_pkg::CMD_BUILD: begin
								if (error_q != coo2csr_pkg::ST_OK) begin
									res_status_q <= error_q;
									state_q      <= S_REPLY;
								end else begin
									idx_q   <= '0;
									acc_q   <= '0;
									state_q <= S_SUM;
								end
							end
							coo2csr_pkg::CMD_RD_PTR: begin
								if (ptr_ok) begin
									state_q <= S_RD_WAIT;
								end else begin
									res_status_q <= coo2csr_pkg::ST_INVALID;
									state_q      <= S_REPLY;
								end
							end
							coo2csr_pkg::CMD_RD_ENTRY: begin
								if (ent_ok) begin
									state_q <= S_RD_WAIT;
								end else begin
									res_status_q <= coo2csr_pkg::ST_INVALID;
									state_q      <= S_REPLY;
								end
							end
							default: begin
								res_status_q <= coo2csr_pkg::ST_INVALID;
								state_q      <= S_REPLY;
							end
						endcase
					end
				end
				S_LD_RD: begin
					state_q <= S_LD_CHK;
				end
				S_LD_CHK: begin
					code_q  <= ld_code;
					state_q <= S_LD_WR;
				end
				S_LD_WR: begin
					if (code_q == coo2csr_pkg::ST_OK) begin
						entry_cnt_q  <= entry_cnt_q + CNT_W'(1);
						res_status_q <= error_q;
					end else if (error_q == coo2csr_pkg::ST_OK) begin
						error_q      <= code_q;
						res_status_q <= code_q;
					end else begin
						res_status_q <= error_q;
					end
					state_q <= S_REPLY;
				end
				S_SUM: begin
					if (v_s1) begin
						acc_q <= alu_res[CNT_W-1:0];
					end
					if (idx_q == ROWS_END) begin
						state_q <= S_SUM_END;
					end else begin
						idx_q <= idx_q + PTR_AW'(1);
					end
				end
				S_SUM_END: begin
					j_q     <= '0;
					state_q <= S_SCAT;
				end
				S_SCAT: begin
					if (coo_re) begin
						j_q <= j_q + CNT_W'(1);
					end
					if ((j_q == entry_cnt_q) && !va_s1 && !vb_s2) begin
						built_q      <= 1'b1;
						res_status_q <= coo2csr_pkg::ST_OK;
						state_q      <= S_REPLY;
					end
				end
				S_RD_WAIT: begin
					state_q <= S_REPLY;
				end
				S_REPLY: begin
					if (reply_load) begin
						m_tvalid_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
		if (s_fire) begin
			cmd_q       <= in_cmd;
			row_q       <= in_row;
			col_q       <= in_col;
			val_q       <= in_val;
			res_start_q <= '0;
			res_col_q   <= '0;
			res_val_q   <= '0;
		end
		if (state_q == S_RD_WAIT) begin
			if (cmd_q == coo2csr_pkg::CMD_RD_PTR) begin
				res_start_q <= coo2csr_pkg::START_W'(rp_rd);
			end else begin
				res_col_q <= csr_rd[VAL_W +: COL_W];
				res_val_q <= csr_rd[VAL_W-1:0];
			end
		end
		if (state_q == S_SCAT) begin
			row_s2    <= coo_rd_row;
			col_s2    <= coo_rd[VAL_W +: COL_W];
			val_s2    <= coo_rd[VAL_W-1:0];
			lw_row_q  <= row_s2;
			lw_slot_q <= alu_res[CNT_W-1:0];
		end
		if (reply_load) begin
			out_status_q <= res_status_q;
			out_start_q  <= res_start_q;
			out_col_q    <= res_col_q;
			out_val_q    <= res_val_q;
			out_total_q  <= coo2csr_pkg::TOTAL_W'(entry_cnt_q);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {{coo2csr_pkg::M_PAD_W{1'b0}}, out_total_q, out_val_q, out_col_q,
		out_start_q};

	coo2csr_ram #(.WIDTH(INFO_W), .DEPTH(MAX_ROWS)) u_info_ram (
		.clk     (clk),
		.wr_en   (info_we),
		.wr_addr (info_wa),
		.wr_data (info_wd),
		.rd_en   (info_re),
		.rd_addr (info_ra),
		.rd_data (info_rd)
	);

	coo2csr_ram #(.WIDTH(CNT_W), .DEPTH(MAX_ROWS + 1)) u_rp_ram (
		.clk     (clk),
		.wr_en   (rp_we),
		.wr_addr (rp_wa),
		.wr_data (rp_wd),
		.rd_en   (rp_re),
		.rd_addr (rp_ra),
		.rd_data (rp_rd)
	);

	coo2csr_ram #(.WIDTH(CNT_W), .DEPTH(MAX_ROWS)) u_slot_ram (
		.clk     (clk),
		.wr_en   (slot_we),
		.wr_addr (slot_wa),
		.wr_data (slot_wd),
		.rd_en   (slot_re),
		.rd_addr (slot_ra),
		.rd_data (slot_rd)
	);

	coo2csr_ram #(.WIDTH(COO_W), .DEPTH(MAX_ENTRIES)) u_coo_ram (
		.clk     (clk),
		.wr_en   (coo_we),
		.wr_addr (coo_wa),
		.wr_data (coo_wd),
		.rd_en   (coo_re),
		.rd_addr (coo_ra),
		.rd_data (coo_rd)
	);

	coo2csr_ram #(.WIDTH(CSR_W), .DEPTH(MAX_ENTRIES)) u_csr_ram (
		.clk     (clk),
		.wr_en   (csr_we),
		.wr_addr (csr_wa),
		.wr_data (csr_wd),
		.rd_en   (csr_re),
		.rd_addr (csr_ra),
		.rd_data (csr_rd)
	);

	coo2csr_alu #(.W(AW)) u_alu (
		.op  (alu_op),
		.a   (alu_a),
		.b   (alu_b),
		.res (alu_res)
	);

	`COO2CSR_ASSERT(a_built_no_error, built_q |-> (error_q == coo2csr_pkg::ST_OK), "built with a pending error")
	`COO2CSR_NEVER(a_count_bound, entry_cnt_q > ENT_FULL, "entry count past capacity")
	`COO2CSR_ASSERT(a_error_sticky, ((error_q != coo2csr_pkg::ST_OK) && !(s_fire && (in_cmd == coo2csr_pkg::CMD_CLEAR))) |=> $stable(error_q), "error code replaced before clear")
	`COO2CSR_ASSERT(a_scatter_slot, ((state_q == S_SCAT) && vb_s2) |-> (slot_eff < entry_cnt_q), "scatter slot past entry count")

endmodule

@@ dv/coo_to_csr_converter_core_tb.sv @@
// Self-checking testbench for the COO to CSR converter core with a predicting scoreboard.
`timescale 1ns / 100ps

module coo_to_csr_converter_core_tb;
	import coo2csr_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int ROW_BITS = $clog2(MAX_ROWS_DEF);
	localparam int COL_MAX = (1 << COL_W) - 1;
	localparam int ROW_FIELD_MAX = (1 << ROW_IN_W) - 1;
	localparam int M_COL_LSB = START_W;
	localparam int M_VAL_LSB = M_COL_LSB + COL_W;
	localparam int M_TOTAL_LSB = M_VAL_LSB + VAL_W;

	typedef struct packed {
		bit [STATUS_W-1:0] status;
		bit [START_W-1:0]  row_start;
		bit [COL_W-1:0]    col;
		bit [VAL_W-1:0]    value;
		bit [TOTAL_W-1:0]  total;
	} csr_response_t;

	class csr_tracker;
		bit [NUM_ROWS_W-1:0] num_rows = NUM_ROWS_RST;
		bit [TOTAL_W-1:0]    row_len [MAX_ROWS_DEF];
		bit [START_W-1:0]    row_ptr [MAX_ROWS_DEF + 1];
		bit [TOTAL_W-1:0]    next_slot [MAX_ROWS_DEF];
		bit [COL_W:0]        last_col [MAX_ROWS_DEF];
		bit [ROW_BITS-1:0]   staged_row [MAX_ENTRIES_DEF];
		bit [COL_W-1:0]      staged_col [MAX_ENTRIES_DEF];
		bit [VAL_W-1:0]      staged_val [MAX_ENTRIES_DEF];
		bit [COL_W-1:0]      packed_col [MAX_ENTRIES_DEF];
		bit [VAL_W-1:0]      packed_val [MAX_ENTRIES_DEF];
		bit [TOTAL_W-1:0]    entry_count;
		bit [STATUS_W-1:0]   err_code;
		bit                  built;
		csr_response_t       expected_responses [$];
		int                  mismatches;
		int                  responses_seen;
		int                  unknown_cmds;
		int                  cmd_count [8];
		int                  status_count [8];

		function int unsigned rows_used();
			if (num_rows == 0) return 1;
			if (num_rows > MAX_ROWS_DEF) return MAX_ROWS_DEF;
			return num_rows;
		endfunction

		function void wipe_rows();
			foreach (row_len[i]) begin
				row_len[i] = '0;
				last_col[i] = '0;
			end
			entry_count = '0;
			err_code = ST_OK;
			built = 1'b0;
		endfunction

		function void build_rows();
			int unsigned r;
			int unsigned slot;
			row_ptr[0] = '0;
			for (int i = 0; i < MAX_ROWS_DEF; i++) begin
				row_ptr[i + 1] = row_ptr[i] + row_len[i];
				next_slot[i] = '0;
			end
			for (int i = 0; i < entry_count; i++) begin
				r = staged_row[i];
				slot = row_ptr[r] + next_slot[r];
				next_slot[r] = next_slot[r] + 1'b1;
				packed_col[slot] = staged_col[i];
				packed_val[slot] = staged_val[i];
			end
			built = 1'b1;
		endfunction

		function void take_command(bit [CMD_W-1:0] cmd, bit [ROW_IN_W-1:0] row,
				bit [COL_W-1:0] col, bit [VAL_W-1:0] val, bit [POS_W-1:0] pos);
			csr_response_t rsp;
			bit [STATUS_W-1:0] code;
			rsp = '0;
			cmd_count[cmd]++;
			case (cmd)
				CMD_CLEAR: wipe_rows();
				CMD_LOAD: begin
					code = ST_OK;
					if (row >= rows_used())
						code = ST_ROW_RANGE;
					else if (entry_count >= MAX_ENTRIES_DEF)
						code = ST_FULL;
					else if (last_col[row] != 0 && {1'b0, col} + 1 <= last_col[row])
						code = ST_UNSORTED;
					built = 1'b0;
					if (code == ST_OK) begin
						last_col[row] = {1'b0, col} + 1'b1;
						row_len[row] = row_len[row] + 1'b1;
						staged_row[entry_count] = row[ROW_BITS-1:0];
						staged_col[entry_count] = col;
						staged_val[entry_count] = val;
						entry_count = entry_count + 1'b1;
					end else if (err_code == ST_OK) begin
						err_code = code;
					end
					rsp.status = err_code;
				end
				CMD_BUILD: begin
					if (err_code != ST_OK)
						rsp.status = err_code;
					else
						build_rows();
				end
				CMD_RD_PTR: begin
					if (built && row <= rows_used())
						rsp.row_start = row_ptr[row];
					else
						rsp.status = ST_INVALID;
				end
				CMD_RD_ENTRY: begin
					if (built && pos < entry_count) begin
						rsp.col = packed_col[pos];
						rsp.value = packed_val[pos];
					end else begin
						rsp.status = ST_INVALID;
					end
				end
				default: begin
					unknown_cmds++;
					rsp.status = ST_INVALID;
				end
			endcase
			rsp.total = entry_count;
			status_count[rsp.status]++;
			expected_responses.push_back(rsp);
		endfunction

		task report(string what, bit [VAL_W-1:0] got, bit [VAL_W-1:0] want);
			if (mismatches < 50)
				$display("MISMATCH response %0d %s: got 0x%0h expected 0x%0h",
					responses_seen, what, got, want);
			mismatches++;
		endtask

		task check_response(bit [STATUS_W-1:0] status, bit [M_TDATA_W-1:0] data);
			csr_response_t want;
			responses_seen++;
			if (expected_responses.size() == 0) begin
				report("response with nothing outstanding", status, '0);
				return;
			end
			want = expected_responses.pop_front();
			if (status != want.status)
				report("status", status, want.status);
			if (data[0 +: START_W] != want.row_start)
				report("row_start", data[0 +: START_W], want.row_start);
			if (data[M_COL_LSB +: COL_W] != want.col)
				report("out_col", data[M_COL_LSB +: COL_W], want.col);
			if (data[M_VAL_LSB +: VAL_W] != want.value)
				report("out_value", data[M_VAL_LSB +: VAL_W], want.value);
			if (data[M_TOTAL_LSB +: TOTAL_W] != want.total)
				report("entry_total", data[M_TOTAL_LSB +: TOTAL_W], want.total);
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [NUM_ROWS_W-1:0] cfg_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata = '0;
	logic [CMD_W-1:0]      s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic [STATUS_W-1:0]   m_tuser;

	csr_tracker  tracker;
	bit          steady = 1'b0;
	int unsigned cycles = 0;

	coo_to_csr_converter_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("coo_to_csr_converter_core_tb: done, errors");
		$finish;
	end

	always @(posedge clk) begin
		m_tready <= steady || ($urandom_range(0, 99) >= 6);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.check_response(m_tuser, m_tdata);
	end

	task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [ROW_IN_W-1:0] row,
			input logic [COL_W-1:0] col, input logic [VAL_W-1:0] val,
			input logic [POS_W-1:0] pos);
		logic [S_TDATA_W-1:0] word;
		word = '0;
		word[S_ROW_LSB +: ROW_IN_W] = row;
		word[S_COL_LSB +: COL_W] = col;
		word[S_VAL_LSB +: VAL_W] = val;
		word[S_POS_LSB +: POS_W] = pos;
		if (!steady && $urandom_range(0, 99) < 6) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < 50);
		end
		s_tvalid <= 1'b1;
		s_tdata <= word;
		s_tuser <= cmd;
		do @(posedge clk); while (!s_tready);
		tracker.take_command(cmd, row, col, val, pos);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (tracker.expected_responses.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_rows(input logic [NUM_ROWS_W-1:0] rows);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= rows;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		tracker.num_rows = rows;
	endtask

	function automatic logic [CMD_W-1:0] unknown_cmd();
		return $urandom_range(int'(CMD_RD_ENTRY) + 1, (1 << CMD_W) - 1);
	endfunction

	task automatic random_phase(input int n_loads, input int n_reads);
		int unsigned rows;
		int unsigned row;
		int unsigned col;
		int unsigned pick;
		int unsigned prev;
		int bad_at;
		rows = tracker.rows_used();
		send_cmd(CMD_CLEAR, $urandom, $urandom, {$urandom, $urandom}, $urandom);
		bad_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n_loads - 1) : -1;
		for (int i = 0; i < n_loads; i++) begin
			if (i == bad_at && (tracker.entry_count == 0 || $urandom_range(0, 1))) begin
				row = (rows > ROW_FIELD_MAX) ? ROW_FIELD_MAX : $urandom_range(rows, ROW_FIELD_MAX);
				col = $urandom;
			end else if (i == bad_at) begin
				row = tracker.staged_row[tracker.entry_count - 1];
				prev = tracker.last_col[row] - 1;
				col = prev - $urandom_range(0, prev);
			end else begin
				row = $urandom_range(0, 1) ? $urandom_range(0, (rows < 16 ? rows : 16) - 1)
					: $urandom_range(0, rows - 1);
				prev = tracker.last_col[row];
				if (prev == 0)
					col = $urandom_range(0, 1) ? $urandom_range(0, 1000) : $urandom_range(0, COL_MAX);
				else if (prev > COL_MAX)
					col = $urandom_range(0, COL_MAX);
				else
					col = prev + $urandom_range(0, 999);
				if (col > COL_MAX)
					col = COL_MAX;
			end
			send_cmd(CMD_LOAD, row, col, {$urandom, $urandom}, $urandom);
		end
		send_cmd(CMD_BUILD, $urandom, $urandom, {$urandom, $urandom}, $urandom);
		for (int i = 0; i < n_reads; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 44)
				send_cmd(CMD_RD_PTR, $urandom_range(0, rows), $urandom, {$urandom, $urandom},
					$urandom);
			else if (pick < 48)
				send_cmd(CMD_RD_PTR, $urandom, $urandom, {$urandom, $urandom}, $urandom);
			else if (pick < 92 && tracker.entry_count != 0)
				send_cmd(CMD_RD_ENTRY, $urandom, $urandom, {$urandom, $urandom},
					$urandom_range(0, tracker.entry_count - 1));
			else if (pick < 95)
				send_cmd(CMD_RD_ENTRY, $urandom, $urandom, {$urandom, $urandom}, $urandom);
			else if (pick < 97)
				send_cmd(unknown_cmd(), $urandom, $urandom, {$urandom, $urandom}, $urandom);
			else if (pick < 99)
				send_cmd(CMD_BUILD, $urandom, $urandom, {$urandom, $urandom}, $urandom);
			else
				send_cmd(CMD_LOAD, $urandom_range(0, rows - 1), $urandom, {$urandom, $urandom},
					$urandom);
		end
	endtask

	initial begin
		logic [NUM_ROWS_W-1:0] row_settings [5];
		int per_row;
		int col_span;
		tracker = new;
		row_settings = '{'0, 11'd1, '1, 11'd1024, 11'd7};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		send_cmd(CMD_RD_PTR, '0, '0, '0, '0);
		send_cmd(CMD_RD_ENTRY, '1, '1, '1, '0);
		send_cmd(unknown_cmd(), '1, '1, '1, '1);
		send_cmd(unknown_cmd(), '0, '0, '0, '0);
		send_cmd(CMD_BUILD, '0, '0, '0, '0);
		send_cmd(CMD_RD_PTR, MAX_ROWS_DEF, '0, '0, '0);
		send_cmd(CMD_RD_PTR, '1, '0, '0, '0);
		send_cmd(CMD_LOAD, '0, '0, '1, '1);
		send_cmd(CMD_LOAD, '0, '1, '0, '0);
		send_cmd(CMD_LOAD, MAX_ROWS_DEF - 1, 16'h1234, {$urandom, $urandom}, '0);
		send_cmd(CMD_LOAD, 11'd5, 16'd7, {$urandom, $urandom}, '0);
		send_cmd(CMD_BUILD, '0, '0, '0, '0);
		for (int p = 0; p < 5; p++)
			send_cmd(CMD_RD_ENTRY, '0, '0, '0, p);
		send_cmd(CMD_RD_PTR, MAX_ROWS_DEF - 1, '0, '0, '0);
		send_cmd(CMD_LOAD, '0, '1, '0, '0);
		send_cmd(CMD_LOAD, MAX_ROWS_DEF, '0, '0, '0);
		send_cmd(CMD_RD_PTR, '0, '0, '0, '0);
		send_cmd(CMD_BUILD, '0, '0, '0, '0);
		send_cmd(CMD_CLEAR, '0, '0, '0, '0);
		send_cmd(CMD_LOAD, 11'd900, 16'd1, {$urandom, $urandom}, '0);
		send_cmd(CMD_LOAD, 11'd2, 16'd3, {$urandom, $urandom}, '0);
		set_rows(11'd7);
		send_cmd(CMD_BUILD, '0, '0, '0, '0);
		send_cmd(CMD_RD_ENTRY, '0, '0, '0, 12'd1);
		send_cmd(CMD_RD_PTR, 11'd7, '0, '0, '0);
		send_cmd(CMD_RD_PTR, 11'd8, '0, '0, '0);

		for (int ph = 0; ph < 10; ph++) begin
			set_rows(ph < 5 ? row_settings[ph] : $urandom_range(1, MAX_ROWS_DEF));
			steady = (ph == 3);
			random_phase($urandom_range(20, 50), $urandom_range(40, 70));
		end
		steady = 1'b0;

		// fill the staging store to the last slot, then overflow it
		set_rows(MAX_ROWS_DEF);
		send_cmd(CMD_CLEAR, '0, '0, '0, '0);
		per_row = MAX_ENTRIES_DEF / MAX_ROWS_DEF;
		col_span = (COL_MAX + 1) / per_row;
		for (int k = 0; k < MAX_ENTRIES_DEF; k++)
			send_cmd(CMD_LOAD, k / per_row, (k % per_row) * col_span + $urandom_range(0, col_span - 1),
				{$urandom, $urandom}, $urandom);
		send_cmd(CMD_BUILD, $urandom, $urandom, {$urandom, $urandom}, $urandom);
		for (int i = 0; i < 30; i++)
			send_cmd(CMD_RD_ENTRY, $urandom, $urandom, {$urandom, $urandom}, $urandom);
		send_cmd(CMD_RD_ENTRY, '0, '0, '0, '1);
		send_cmd(CMD_RD_PTR, MAX_ROWS_DEF, '0, '0, '0);
		send_cmd(CMD_RD_PTR, $urandom_range(0, MAX_ROWS_DEF), '0, '0, '0);
		send_cmd(CMD_LOAD, 11'd5, '1, '1, '0);
		send_cmd(CMD_BUILD, '0, '0, '0, '0);
		send_cmd(CMD_RD_ENTRY, '0, '0, '0, '0);
		send_cmd(CMD_CLEAR, '0, '0, '0, '0);

		s_tvalid <= 1'b0;
		while (tracker.expected_responses.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("run: %0d clears, %0d loads, %0d builds, %0d pointer reads, %0d entry reads, %0d unknown",
			tracker.cmd_count[CMD_CLEAR], tracker.cmd_count[CMD_LOAD], tracker.cmd_count[CMD_BUILD],
			tracker.cmd_count[CMD_RD_PTR], tracker.cmd_count[CMD_RD_ENTRY], tracker.unknown_cmds);
		$display("run: status unsorted %0d, row range %0d, full %0d, invalid %0d; %0d responses checked",
			tracker.status_count[ST_UNSORTED], tracker.status_count[ST_ROW_RANGE],
			tracker.status_count[ST_FULL], tracker.status_count[ST_INVALID], tracker.responses_seen);
		if (tracker.mismatches == 0)
			$display("coo_to_csr_converter_core_tb: done, clean");
		else
			$display("coo_to_csr_converter_core_tb: done, errors");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/coo2csr_pkg.sv
rtl/core/coo2csr_ram.sv
rtl/core/coo2csr_alu.sv
rtl/core/coo_to_csr_converter_core.sv
dv/coo_to_csr_converter_core_tb.sv
